FILE: design/dsmp_pkg.sv
// Shared types and constants of the discrete unsigned random sampler.
package dsmp_pkg;

  localparam logic [1:0] OMODE_INT   = 2'd0;
  localparam logic [1:0] OMODE_RANGE = 2'd1;
  localparam logic [1:0] OMODE_CONST = 2'd2;
  localparam logic [1:0] OMODE_ENUM  = 2'd3;

  localparam logic [1:0] DMODE_NONE     = 2'd0;
  localparam logic [1:0] DMODE_UNIFORM  = 2'd1;
  localparam logic [1:0] DMODE_DISCRETE = 2'd2;

  localparam logic [2:0] REG_OUTPUT_MODE = 3'd0;
  localparam logic [2:0] REG_DIST_MODE   = 3'd1;
  localparam logic [2:0] REG_RANGE_MIN   = 3'd2;
  localparam logic [2:0] REG_RANGE_MAX   = 3'd3;
  localparam logic [2:0] REG_TABLE_COUNT = 3'd4;
  localparam logic [2:0] REG_SEED        = 3'd5;

  localparam logic [34:0] LCG_MUL    = 35'h5DEECE66D;
  localparam logic [47:0] LCG_ADD    = 48'hB;
  localparam logic [47:0] SEED_RESET = 48'd13070;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LCG_LO, ST_LCG_HI, ST_WALK_RD, ST_WALK_SUB, ST_MUL_LO, ST_MUL_HI,
    ST_SCALE, ST_DIV_LOAD, ST_DIV, ST_IDX, ST_VAL_RD, ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_WRITE, OP_LCG_LO, OP_LCG_HI, OP_WALK_RD, OP_WALK_SUB, OP_MUL_LO,
    OP_MUL_HI, OP_SCALE, OP_DIV_LOAD, OP_DIV_STEP, OP_IDX, OP_VAL_RD, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } dsmp_cmd_t;

  typedef struct packed {
    logic walk_stop;
    logic div_last;
  } dsmp_stat_t;

  typedef struct packed {
    logic [1:0]  output_mode;
    logic [1:0]  distribution_mode;
    logic [31:0] range_min;
    logic [31:0] range_max;
    logic [4:0]  table_count;
  } dsmp_cfg_t;

endpackage

FILE: design/dsmp_ctrl.sv
// Sequencer that steps the sampler datapath through one transaction.
module dsmp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                action,
  input  dsmp_pkg::dsmp_cfg_t cfg,
  input  dsmp_pkg::dsmp_stat_t stat,
  output dsmp_pkg::dsmp_cmd_t cmd,
  output logic                busy
);
  import dsmp_pkg::*;

  state_t state, state_next;
  state_t route;
  logic   discrete;
  logic   dist_ok;

  assign discrete = (cfg.distribution_mode == DMODE_DISCRETE);
  assign dist_ok  = (cfg.distribution_mode == DMODE_UNIFORM) || discrete;
  assign busy     = (state != ST_IDLE);

  // pick the mapping stage once the fraction or index is known
  always_comb begin
    priority if (cfg.output_mode == OMODE_INT) begin
      route = ST_EMIT;
    end else if (cfg.output_mode == OMODE_RANGE) begin
      route = discrete ? ST_DIV_LOAD : ST_MUL_LO;
    end else begin
      route = ST_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (action) begin
            cmd.op = OP_WRITE;
          end else if (cfg.output_mode == OMODE_CONST || !dist_ok) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_LCG_LO;
          end
        end
      end
      ST_LCG_LO: begin
        cmd.op     = OP_LCG_LO;
        state_next = ST_LCG_HI;
      end
      ST_LCG_HI: begin
        cmd.op     = OP_LCG_HI;
        state_next = discrete ? ST_WALK_RD : route;
      end
      ST_WALK_RD: begin
        cmd.op     = OP_WALK_RD;
        state_next = ST_WALK_SUB;
      end
      ST_WALK_SUB: begin
        cmd.op     = OP_WALK_SUB;
        state_next = stat.walk_stop ? route : ST_WALK_RD;
      end
      ST_MUL_LO: begin
        cmd.op     = OP_MUL_LO;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.op     = OP_MUL_HI;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.op     = OP_SCALE;
        state_next = ST_EMIT;
      end
      ST_DIV_LOAD: begin
        cmd.op     = OP_DIV_LOAD;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op     = OP_DIV_STEP;
        state_next = stat.div_last ? ST_EMIT : ST_DIV;
      end
      ST_IDX: begin
        cmd.op     = OP_IDX;
        state_next = ST_VAL_RD;
      end
      ST_VAL_RD: begin
        cmd.op     = OP_VAL_RD;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.op     = OP_EMIT;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/dsmp_dpath.sv
// Generator, table memories, walk, scaling, divider and result registers.
module dsmp_dpath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dsmp_pkg::dsmp_cmd_t  cmd,
  output dsmp_pkg::dsmp_stat_t stat,
  input  dsmp_pkg::dsmp_cfg_t  cfg,
  input  logic                 seed_we,
  input  logic [47:0]          seed_value,
  input  logic [3:0]           entry_index,
  input  logic [31:0]          entry_probability,
  input  logic [31:0]          entry_value,
  output logic                 done,
  output logic [31:0]          drawn_value,
  output logic                 no_distribution_error
);
  import dsmp_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = CW + 32;
  localparam int KW = $clog2(DW + 1);

  logic [31:0] prob_mem [TABLE_DEPTH];
  logic [31:0] val_mem  [TABLE_DEPTH];
  logic [31:0] prob_q, val_q;

  logic [47:0]    lcg, part;
  logic signed [48:0] rem;
  logic [CW-1:0]  num, idx, count, idx_c;
  logic [55:0]    prod_lo, prod_hi;
  logic [31:0]    scaled;
  logic [DW-1:0]  dq;
  logic [CW-1:0]  rmd;
  logic [KW-1:0]  dcnt;

  logic              discrete, dist_ok;
  logic [31:0]       diff;
  logic [58:0]       lo_prod;
  logic [47:0]       hi_prod, lcg_new;
  logic signed [48:0] rem_n;
  logic              rem_done;
  logic [CW-1:0]     num_inc;
  logic [56:0]       scale_sum;
  logic [CW:0]       trial, trial_sub;
  logic [CW+47:0]    idx_prod;
  logic [AW-1:0]     rd_addr;
  logic              wr_ok;
  logic [31:0]       range_sum, range_res, res_value;
  logic              res_err;

  assign discrete = (cfg.distribution_mode == DMODE_DISCRETE);
  assign dist_ok  = (cfg.distribution_mode == DMODE_UNIFORM) || discrete;
  assign diff     = cfg.range_max - cfg.range_min;

  // effective entry count: zero acts as one, saturate at the table depth
  always_comb begin
    if (cfg.table_count == 5'd0) begin
      count = CW'(1);
    end else if (32'(cfg.table_count) > 32'(TABLE_DEPTH)) begin
      count = CW'(TABLE_DEPTH);
    end else begin
      count = CW'(cfg.table_count);
    end
  end

  // table write port
  assign wr_ok = (32'(entry_index) < 32'(TABLE_DEPTH));
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && wr_ok) begin
      prob_mem[AW'(entry_index)] <= entry_probability;
      val_mem[AW'(entry_index)]  <= entry_value;
    end
  end

  // table read port, registered
  assign idx_c   = (idx > count - CW'(1)) ? count - CW'(1) : idx;
  assign rd_addr = (cmd.op == OP_WALK_RD) ? num[AW-1:0] : idx_c[AW-1:0];
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WALK_RD || cmd.op == OP_VAL_RD) begin
      prob_q <= prob_mem[rd_addr];
      val_q  <= val_mem[rd_addr];
    end
  end

  // generator: low partial product first, high half and increment next
  assign lo_prod = 59'(lcg[23:0]) * 59'(LCG_MUL);
  assign hi_prod = 48'(lcg[47:24]) * 48'(LCG_MUL[23:0]);
  assign lcg_new = part + {hi_prod[23:0], 24'd0} + LCG_ADD;

  assign rem_n    = rem - $signed({1'b0, prob_q, 16'd0});
  assign rem_done = rem_n[48] || (rem_n == '0);
  assign num_inc  = num + CW'(1);
  assign stat.walk_stop = rem_done || (num_inc >= count);

  assign scale_sum = 57'(prod_hi) + 57'(prod_lo[55:24]);
  assign idx_prod  = (CW + 48)'(count) * (CW + 48)'(lcg);

  assign trial     = {rmd, dq[DW-1]};
  assign trial_sub = trial - {1'b0, count};
  assign stat.div_last = (dcnt == KW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg <= SEED_RESET;
    end else if (seed_we) begin
      lcg <= seed_value;
    end else if (cmd.op == OP_LCG_HI) begin
      lcg <= lcg_new;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LCG_LO: part <= lo_prod[47:0];
      OP_LCG_HI: begin
        rem <= $signed({1'b0, lcg_new});
        num <= '0;
      end
      OP_WALK_SUB: begin
        rem <= rem_n;
        if (!rem_done) begin
          num <= num_inc;
        end
      end
      OP_MUL_LO: prod_lo <= 56'(lcg[23:0]) * 56'(diff);
      OP_MUL_HI: prod_hi <= 56'(lcg[47:24]) * 56'(diff);
      OP_SCALE:  scaled  <= scale_sum[55:24];
      OP_DIV_LOAD: begin
        dq   <= DW'(num) * DW'(diff);
        rmd  <= '0;
        dcnt <= KW'(DW);
      end
      OP_DIV_STEP: begin
        // restoring division, one quotient bit shifted in per step
        if (trial >= {1'b0, count}) begin
          rmd <= trial_sub[CW-1:0];
          dq  <= {dq[DW-2:0], 1'b1};
        end else begin
          rmd <= trial[CW-1:0];
          dq  <= {dq[DW-2:0], 1'b0};
        end
        dcnt <= dcnt - KW'(1);
      end
      OP_IDX: idx <= discrete ? num : idx_prod[CW+47:48];
      default: begin
      end
    endcase
  end

  // result mapping
  assign range_sum = cfg.range_min + (discrete ? dq[31:0] : scaled);
  assign range_res = (range_sum > cfg.range_max) ? cfg.range_max : range_sum;

  always_comb begin
    res_err = 1'b0;
    unique case (cfg.output_mode)
      OMODE_INT:   res_value = 32'(discrete && (num >= count));
      OMODE_RANGE: res_value = range_res;
      OMODE_CONST: res_value = cfg.range_min;
      OMODE_ENUM:  res_value = val_q;
      default:     res_value = '0;
    endcase
    if (cfg.output_mode != OMODE_CONST && !dist_ok) begin
      res_value = '0;
      res_err   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.op == OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      drawn_value           <= res_value;
      no_distribution_error <= res_err;
    end
  end

endmodule

FILE: design/discrete_uint_random_sampler_top.sv
// Top level of the discrete unsigned random sampler: config registers and wiring.
//
// Usage: raise start while busy is low to issue one transaction. With action 1
// the transaction writes probability and value table entry entry_index (an
// index beyond the table is dropped); busy stays low and no result follows.
// With action 0 the transaction draws one value; done is high for exactly one
// cycle with drawn_value and no_distribution_error. Constant mode and an
// invalid distribution mode go straight to the result; other draws first step
// the generator. A discrete draw then walks the table, one memory read and one
// subtract per entry visited; a discrete range draw replaces the two multiplies
// with a bit-serial divider of CW+32 quotient bits (37 for a 16-entry table).
// busy is low again in the cycle done rises, so a new transaction may start
// there. Config writes (cfg_we, cfg_index, cfg_data) take effect at once; the
// user must make them while no draw is in flight; the block does not enforce
// it. Writing the seed reloads the generator. Reset loads the register defaults
// and the generator seed 13070; the table contents are undefined until written.
// Results cannot be stalled.
module discrete_uint_random_sampler_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [3:0]  entry_index,
  input  logic [31:0] entry_probability,
  input  logic [31:0] entry_value,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output logic        done,
  output logic [31:0] drawn_value,
  output logic        no_distribution_error
);
  import dsmp_pkg::*;

  dsmp_cfg_t  cfg;
  dsmp_cmd_t  cmd;
  dsmp_stat_t stat;
  logic       seed_we;

  assign seed_we = cfg_we && (cfg_index == REG_SEED);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_mode       <= OMODE_RANGE;
      cfg.distribution_mode <= DMODE_UNIFORM;
      cfg.range_min         <= '0;
      cfg.range_max         <= '0;
      cfg.table_count       <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUTPUT_MODE: cfg.output_mode       <= cfg_data[1:0];
        REG_DIST_MODE:   cfg.distribution_mode <= cfg_data[1:0];
        REG_RANGE_MIN:   cfg.range_min         <= cfg_data[31:0];
        REG_RANGE_MAX:   cfg.range_max         <= cfg_data[31:0];
        REG_TABLE_COUNT: cfg.table_count       <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  dsmp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .cfg    (cfg),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  dsmp_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .stat                  (stat),
    .cfg                   (cfg),
    .seed_we               (seed_we),
    .seed_value            (cfg_data),
    .entry_index           (entry_index),
    .entry_probability     (entry_probability),
    .entry_value           (entry_value),
    .done                  (done),
    .drawn_value           (drawn_value),
    .no_distribution_error (no_distribution_error)
  );

`ifndef SYNTH
  // a result only follows a cycle in which a draw was in flight
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a draw in flight");

  // a table write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action) |=> !done)
    else $error("table write produced a result");

  // an error result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && no_distribution_error) |-> (drawn_value == 32'd0))
    else $error("error result with nonzero value");
`endif

endmodule

FILE: sim/tb_discrete_uint_random_sampler_top.sv
// Testbench for the discrete unsigned random sampler: scoreboard prediction, directed and random draws.
`timescale 1ns / 1ps
module tb_discrete_uint_random_sampler_top;
  import dsmp_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 1000000;

  class sampler_scoreboard;
    logic [1:0]  out_mode, dist_mode;
    logic [31:0] rng_min, rng_max;
    logic [4:0]  tbl_count;
    logic [47:0] gen_state;
    logic [31:0] prob_tbl[DEPTH];
    logic [31:0] val_tbl[DEPTH];
    logic [31:0] want_value[$];
    logic        want_err[$];
    int          errors;

    function new();
      out_mode  = OMODE_RANGE;
      dist_mode = DMODE_UNIFORM;
      rng_min   = '0;
      rng_max   = '0;
      tbl_count = 5'd1;
      gen_state = SEED_RESET;
      errors    = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [47:0] data);
      case (idx)
        REG_OUTPUT_MODE: out_mode = data[1:0];
        REG_DIST_MODE:   dist_mode = data[1:0];
        REG_RANGE_MIN:   rng_min = data[31:0];
        REG_RANGE_MAX:   rng_max = data[31:0];
        REG_TABLE_COUNT: tbl_count = data[4:0];
        REG_SEED:        gen_state = data;
        default: ;
      endcase
    endfunction

    // Predict the result of one accepted transaction.
    function void note(logic act, logic [3:0] idx, logic [31:0] prob, logic [31:0] val);
      int          cnt, n, sel;
      longint      rem;
      logic [95:0] nxt;
      logic [79:0] wide;
      logic [63:0] frac;
      logic [31:0] diff, res;
      bit          disc;
      if (act) begin
        prob_tbl[idx] = prob;
        val_tbl[idx]  = val;
        return;
      end
      if (out_mode == OMODE_CONST) begin
        want_value.push_back(rng_min);
        want_err.push_back(1'b0);
        return;
      end
      if (dist_mode != DMODE_UNIFORM && dist_mode != DMODE_DISCRETE) begin
        want_value.push_back('0);
        want_err.push_back(1'b1);
        return;
      end
      cnt = (tbl_count == 0) ? 1 : (tbl_count > DEPTH) ? DEPTH : int'(tbl_count);
      nxt = {48'b0, gen_state} * 96'(LCG_MUL) + 96'(LCG_ADD);
      gen_state = nxt[47:0];
      disc = (dist_mode == DMODE_DISCRETE);
      n = 0;
      if (disc) begin
        rem = longint'({16'b0, gen_state});
        forever begin
          rem -= longint'({16'b0, prob_tbl[n], 16'b0});
          if (rem <= 0) break;
          n++;
          if (n >= cnt) break;
        end
      end
      diff = rng_max - rng_min;
      if (out_mode == OMODE_INT) begin
        res = (disc && n >= cnt) ? 32'd1 : 32'd0;
      end else if (out_mode == OMODE_RANGE) begin
        if (disc) begin
          frac = (64'(n) * 64'(diff)) / 64'(cnt);
        end else begin
          wide = {32'b0, gen_state} * {48'b0, diff};
          frac = 64'(wide >> 48);
        end
        res = rng_min + frac[31:0];
        if (res > rng_max) res = rng_max;
      end else begin
        if (disc) begin
          sel = n;
        end else begin
          wide = {32'b0, gen_state} * 80'(cnt);
          sel = int'(wide >> 48);
        end
        if (sel > cnt - 1) sel = cnt - 1;
        res = val_tbl[sel];
      end
      want_value.push_back(res);
      want_err.push_back(1'b0);
    endfunction

    function void check(logic [31:0] val, logic err);
      logic [31:0] ev;
      logic        ee;
      if (want_value.size() == 0) begin
        $error("unexpected result: drawn_value %0h no_distribution_error %0b", val, err);
        errors++;
        return;
      end
      ev = want_value.pop_front();
      ee = want_err.pop_front();
      if (val !== ev) begin
        $error("drawn_value: expected %0h actual %0h", ev, val);
        errors++;
      end
      if (err !== ee) begin
        $error("no_distribution_error: expected %0b actual %0b", ee, err);
        errors++;
      end
    endfunction

    function int pending();
      return want_value.size();
    endfunction
  endclass

  logic        clk, rst, start, busy, action, cfg_we, done, no_distribution_error;
  logic [3:0]  entry_index;
  logic [31:0] entry_probability, entry_value, drawn_value;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  sampler_scoreboard sb;
  int cycles;
  int idle_pct;

  discrete_uint_random_sampler_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .entry_index(entry_index), .entry_probability(entry_probability),
    .entry_value(entry_value), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .drawn_value(drawn_value),
    .no_distribution_error(no_distribution_error)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check(drawn_value, no_distribution_error);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Drop start and drain outstanding draws, then write one register.
  task automatic write_reg(logic [2:0] idx, logic [47:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Issue one transaction; hold start until it is accepted, then maybe idle.
  task automatic send(logic act, logic [3:0] idx, logic [31:0] prob, logic [31:0] val);
    start             <= 1'b1;
    action            <= act;
    entry_index       <= idx;
    entry_probability <= prob;
    entry_value       <= val;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note(act, idx, prob, val);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  // Drain all outstanding draws before touching the registers.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_prob();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h1FFF_FFFF);
    endcase
  endfunction

  task automatic draw();
    send(1'b0, 4'($urandom), $urandom, $urandom);
  endtask

  initial begin
    sb = new();
    cycles = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    action = 1'b0;
    entry_index = '0;
    entry_probability = '0;
    entry_value = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset defaults, then fill both tables (small probabilities plus zero and all-ones entries).
    draw();
    for (int i = 0; i < DEPTH; i++)
      send(1'b1, 4'(i), (i == 0) ? 32'd0 : (i == 15) ? 32'hFFFF_FFFF : 32'h0100_0000 * i,
           (i == 3) ? 32'hFFFF_FFFF : 32'hA500_0000 + i);
    settle();
    write_reg(REG_DIST_MODE, 48'(DMODE_DISCRETE));
    write_reg(REG_TABLE_COUNT, 48'd16);
    write_reg(REG_RANGE_MAX, 48'hFFFF_FFFF);
    write_reg(REG_SEED, 48'hFFFF_FFFF_FFFF);
    draw();
    write_reg(REG_OUTPUT_MODE, 48'(OMODE_INT));
    draw();
    write_reg(REG_OUTPUT_MODE, 48'(OMODE_ENUM));
    draw();
    write_reg(REG_TABLE_COUNT, 48'd0);
    write_reg(REG_DIST_MODE, 48'(DMODE_UNIFORM));
    draw();
    write_reg(REG_TABLE_COUNT, 48'd31);
    draw();
    write_reg(REG_DIST_MODE, 48'(DMODE_NONE));
    draw();
    write_reg(REG_DIST_MODE, 48'd3);
    draw();
    write_reg(REG_OUTPUT_MODE, 48'(OMODE_CONST));
    write_reg(REG_RANGE_MIN, 48'hFFFF_FFFF);
    draw();
    write_reg(REG_OUTPUT_MODE, 48'(OMODE_RANGE));
    write_reg(REG_DIST_MODE, 48'(DMODE_UNIFORM));
    write_reg(REG_RANGE_MAX, 48'd5);
    write_reg(REG_SEED, 48'd0);
    draw();
    settle();

    // Random phases: sender idles 10 %, then 45 %, then never.
    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = (ph < 4) ? 10 : (ph < 8) ? 45 : 0;
      write_reg(REG_OUTPUT_MODE, 48'($urandom_range(3)));
      write_reg(REG_DIST_MODE, 48'(($urandom_range(9) == 0) ? $urandom_range(3)
                                   : $urandom_range(1, 2)));
      write_reg(REG_RANGE_MIN, 48'(pick32()));
      write_reg(REG_RANGE_MAX, 48'(pick32()));
      write_reg(REG_TABLE_COUNT, 48'(($urandom_range(4) == 0) ? $urandom_range(31)
                                     : $urandom_range(1, 16)));
      case ($urandom_range(3))
        0: write_reg(REG_SEED, 48'd0);
        1: write_reg(REG_SEED, 48'hFFFF_FFFF_FFFF);
        default: write_reg(REG_SEED, {16'($urandom), 32'($urandom)});
      endcase
      for (int k = 0; k < 160; k++) begin
        if ($urandom_range(99) < 15) send(1'b1, 4'($urandom), pick_prob(), $urandom);
        else draw();
      end
      settle();
    end

    repeat (50) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
